// File: rtl/ssm_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ssm_pkg: shared types and constants of the substring first-match search
// Byte width, item kind codes and the control word that drives the cell chain.
// ----------------------------------------------------------------------------
package ssm_pkg;

  localparam int SymW = 8;

  // kind field codes
  localparam logic KindPattern = 1'b0;
  localparam logic KindText    = 1'b1;

  // control word broadcast to every cell of the chain
  typedef struct packed {
    logic shift_text; // text byte moves one cell toward the oldest end
    logic shift_pat;  // pattern byte and active bit move one cell
  } cell_ctrl_t;

endpackage : ssm_pkg
`default_nettype wire

// File: rtl/ssm_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ssm_if: valid/ready channels of the substring first-match search
// ssm_in_if carries pattern and text items, ssm_res_if carries result items.
// ----------------------------------------------------------------------------
interface ssm_in_if import ssm_pkg::*; ();
  logic            valid;
  logic            ready;
  logic            kind;
  logic [SymW-1:0] symbol;
  logic            first;
  logic            last;

  modport source (output valid, kind, symbol, first, last, input ready);
  modport sink   (input valid, kind, symbol, first, last, output ready);
endinterface : ssm_in_if

interface ssm_res_if #(
  parameter int POSITION_BITS = 16
) ();
  logic                     valid;
  logic                     ready;
  logic                     found;
  logic [POSITION_BITS-1:0] position;
  logic                     pattern_overflow;

  modport source (output valid, found, position, pattern_overflow, input ready);
  modport sink   (input valid, found, position, pattern_overflow, output ready);
endinterface : ssm_res_if
`default_nettype wire

// File: rtl/ssm_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ssm_cell: one position of the window compare chain
// Holds one text byte, one pattern byte and an active bit; compares the text
// byte arriving from its neighbor with its pattern byte.
// ----------------------------------------------------------------------------
module ssm_cell import ssm_pkg::*; (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire cell_ctrl_t      ctrl_i,
  input  wire logic [SymW-1:0] txt_i,
  input  wire logic [SymW-1:0] pat_i,
  input  wire logic            act_i,
  output logic      [SymW-1:0] txt_o,
  output logic      [SymW-1:0] pat_o,
  output logic                 act_o,
  output logic                 hit_o
);

  logic [SymW-1:0] txt_q, pat_q;
  logic            act_q;

  // text and pattern bytes carry no reset
  always_ff @(posedge clk_i) begin
    if (ctrl_i.shift_text) begin
      txt_q <= txt_i;
    end
    if (ctrl_i.shift_pat) begin
      pat_q <= pat_i;
    end
  end

  // active bit marks a cell that holds a written pattern byte
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_q <= 1'b0;
    end else if (ctrl_i.shift_pat) begin
      act_q <= act_i;
    end
  end

  // compare against the byte this cell takes on the current text item
  assign hit_o = !act_q || (txt_i == pat_q);
  assign txt_o = txt_q;
  assign pat_o = pat_q;
  assign act_o = act_q;

endmodule : ssm_cell
`default_nettype wire

// File: rtl/substring_first_match.sv
`default_nettype none
// Result: a result item is presented in the cycle after the text item marked last.
// Throughput: one item per cycle; every cell of the chain shifts and compares
// in the same cycle, and the result register only stalls the input while a
// previous result is still not taken.
// Reset: pattern length, overflow flag, search state and active bits clear at
// once; pattern and window bytes are undefined until shifted in.
// ----------------------------------------------------------------------------
// substring_first_match: first occurrence of a stored pattern in a text stream
// Pattern bytes and text bytes shift through a chain of compare cells; the
// earliest match start is kept and reported on the last text item.
// ----------------------------------------------------------------------------
module substring_first_match import ssm_pkg::*; #(
  parameter int MAX_PATTERN   = 32,
  parameter int POSITION_BITS = 16
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  ssm_in_if.sink     in_i,
  ssm_res_if.source  out_o
);

  localparam int LenW = $clog2(MAX_PATTERN + 1);
  localparam longint unsigned CountSat = (64'd1 << POSITION_BITS) + 64'(MAX_PATTERN);
  localparam int CntW = $clog2(CountSat + 64'd1);
  localparam logic [CntW-1:0] CntSat = CntW'(CountSat);
  localparam logic [CntW-1:0] PosMax = CntW'((64'd1 << POSITION_BITS) - 64'd1);
  localparam logic [LenW-1:0] LenMax = LenW'(MAX_PATTERN);

  logic                     accept;
  logic                     pat_item, txt_item;
  cell_ctrl_t               ctrl;
  logic [LenW-1:0]          len_q, len_d;
  logic                     ovf_q, ovf_d;
  logic [CntW-1:0]          cnt_q, cnt_d, cnt_base, cnt_new, start;
  logic                     seen_q, seen_d, seen_base;
  logic [POSITION_BITS-1:0] mstart_q, mstart_d;
  logic                     hit_all, match_now;
  logic                     res_valid_q, res_found_q, res_ovf_q;
  logic [POSITION_BITS-1:0] res_pos_q;

  logic [SymW-1:0]        txt_w [MAX_PATTERN];
  logic [SymW-1:0]        pat_w [MAX_PATTERN];
  logic [MAX_PATTERN-1:0] act_w;
  logic [MAX_PATTERN-1:0] hit_w;

  // handshake and item decode
  assign in_i.ready = !res_valid_q || out_o.ready;
  assign accept     = in_i.valid && in_i.ready;
  assign pat_item   = accept && (in_i.kind == KindPattern);
  assign txt_item   = accept && (in_i.kind == KindText);

  // pattern append: dropped once the chain is full, unless it restarts
  assign ctrl.shift_text = txt_item;
  assign ctrl.shift_pat  = pat_item && (in_i.first || (len_q != LenMax));

  // cell chain, newest byte enters at the top cell
  for (genvar w = 0; w < MAX_PATTERN; w++) begin : g_cell
    logic [SymW-1:0] txt_in, pat_in;
    logic            act_in;
    if (w == MAX_PATTERN - 1) begin : g_head
      assign txt_in = in_i.symbol;
      assign pat_in = in_i.symbol;
      assign act_in = 1'b1;
    end else begin : g_body
      assign txt_in = txt_w[w+1];
      assign pat_in = pat_w[w+1];
      assign act_in = act_w[w+1] && !in_i.first;
    end
    ssm_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctrl_i (ctrl),
      .txt_i  (txt_in),
      .pat_i  (pat_in),
      .act_i  (act_in),
      .txt_o  (txt_w[w]),
      .pat_o  (pat_w[w]),
      .act_o  (act_w[w]),
      .hit_o  (hit_w[w])
    );
  end

  assign hit_all = &hit_w;

  // pattern length and overflow flag
  always_comb begin
    len_d = len_q;
    ovf_d = ovf_q;
    if (pat_item) begin
      if (in_i.first) begin
        len_d = LenW'(1);
        ovf_d = 1'b0;
      end else if (len_q != LenMax) begin
        len_d = len_q + LenW'(1);
      end else begin
        ovf_d = 1'b1;
      end
    end
  end

  // text counter and earliest match
  always_comb begin
    cnt_base  = in_i.first ? '0 : cnt_q;
    seen_base = in_i.first ? 1'b0 : seen_q;
    cnt_new   = (cnt_base < CntSat) ? cnt_base + CntW'(1) : cnt_base;
    start     = cnt_new - CntW'(len_q);
    match_now = !seen_base && (len_q != '0) && (cnt_new >= CntW'(len_q)) &&
                hit_all && (start <= PosMax);
    cnt_d     = cnt_q;
    seen_d    = seen_q;
    mstart_d  = mstart_q;
    if (txt_item) begin
      if (in_i.last) begin
        cnt_d    = '0;
        seen_d   = 1'b0;
        mstart_d = '0;
      end else begin
        cnt_d    = cnt_new;
        seen_d   = seen_base || match_now;
        mstart_d = match_now ? start[POSITION_BITS-1:0] :
                   (in_i.first ? '0 : mstart_q);
      end
    end
  end

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q    <= '0;
      ovf_q    <= 1'b0;
      cnt_q    <= '0;
      seen_q   <= 1'b0;
      mstart_q <= '0;
    end else begin
      len_q    <= len_d;
      ovf_q    <= ovf_d;
      cnt_q    <= cnt_d;
      seen_q   <= seen_d;
      mstart_q <= mstart_d;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (txt_item && in_i.last) begin
      res_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      res_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (txt_item && in_i.last) begin
      res_ovf_q <= ovf_q;
      if (len_q == '0) begin
        res_found_q <= 1'b1;
        res_pos_q   <= '0;
      end else if (seen_base || match_now) begin
        res_found_q <= 1'b1;
        res_pos_q   <= match_now ? start[POSITION_BITS-1:0] : mstart_q;
      end else begin
        res_found_q <= 1'b0;
        res_pos_q   <= '0;
      end
    end
  end

  assign out_o.valid            = res_valid_q;
  assign out_o.found            = res_found_q;
  assign out_o.position         = res_pos_q;
  assign out_o.pattern_overflow = res_ovf_q;

`ifndef SYNTHESIS
  // a result appears only after an accepted last text item
  a_res_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(res_valid_q) |-> $past(txt_item && in_i.last))
    else $error("result without last text item");

  // active cells count the stored pattern bytes
  a_act_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(act_w) == int'(len_q))
    else $error("active mask disagrees with pattern length");

  // position is zero when nothing was found
  a_pos_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_q && !res_found_q) |-> (res_pos_q == '0))
    else $error("nonzero position on not found");

  // pattern length stays within capacity
  a_len_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    len_q <= LenMax)
    else $error("pattern length beyond capacity");
`endif

endmodule : substring_first_match
`default_nettype wire
